FILE: rtl/core/hbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbc_pkg
// Shared types and constants for the hashed LRU buffer cache.
// ----------------------------------------------------------------------------
package hbc_pkg;

  localparam int unsigned NumSlots   = 32;
  localparam int unsigned NumBuckets = 13;
  localparam int unsigned SlotW      = $clog2(NumSlots);
  localparam int unsigned BucketW    = $clog2(NumBuckets);

  typedef enum logic [1:0] {
    OP_GET     = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PIN     = 2'd2,
    OP_UNPIN   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FILL  = 2'd1,
    ST_NOBUF = 2'd2,
    ST_BADREF = 2'd3
  } status_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  device;
    logic [31:0] block_number;
    logic [4:0]  slot_in;
    logic [31:0] now;
    logic [BucketW-1:0] home;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_HIT,
    BK_VICT,
    BK_APPLY,
    BK_DONE
  } bk_state_e;

  // bucket of a block: residue mod NumBuckets, 4 bits per step
  // r < NumBuckets, so {r, nib} < 16 * NumBuckets: four compare-subtract steps
  function automatic logic [BucketW-1:0] bucket_step(logic [BucketW-1:0] r,
                                                      logic [3:0] nib);
    logic [BucketW+4:0] t;
    t = {1'b0, r, nib};
    if (t >= (BucketW+5)'(NumBuckets * 8)) t = t - (BucketW+5)'(NumBuckets * 8);
    if (t >= (BucketW+5)'(NumBuckets * 4)) t = t - (BucketW+5)'(NumBuckets * 4);
    if (t >= (BucketW+5)'(NumBuckets * 2)) t = t - (BucketW+5)'(NumBuckets * 2);
    if (t >= (BucketW+5)'(NumBuckets)) t = t - (BucketW+5)'(NumBuckets);
    return t[BucketW-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/hbc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbc_front
// Accepts commands, computes the home bucket one nibble a cycle, and pushes
// the classified command into a two-entry queue.
// ----------------------------------------------------------------------------
module hbc_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [1:0]         op_i,
  input  wire logic [7:0]         device_i,
  input  wire logic [31:0]        block_number_i,
  input  wire logic [4:0]         slot_in_i,
  input  wire logic [31:0]        now_i,
  output logic                    busy_o,
  input  wire logic               pop_i,
  output logic                    q_valid_o,
  output hbc_pkg::cmd_t           q_cmd_o
);

  hbc_pkg::cmd_t cmd_q, cmd_d;
  logic          act_q, act_d;
  logic [2:0]    nib_q, nib_d;
  hbc_pkg::cmd_t fifo_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic          push;
  hbc_pkg::cmd_t push_cmd;

  logic [3:0] cur_nib;
  assign cur_nib = cmd_q.block_number[31 - 4*nib_q -: 4];

  // one command in the front or its queue at a time; back handles it sequentially
  assign busy_o = act_q | (cnt_q != 2'd0);
  assign push   = act_q && (nib_q == 3'd7);

  always_comb begin
    cmd_d = cmd_q;
    act_d = act_q;
    nib_d = nib_q;
    if (start_i && !busy_o) begin
      cmd_d.op           = hbc_pkg::op_e'(op_i);
      cmd_d.device       = device_i;
      cmd_d.block_number = block_number_i;
      cmd_d.slot_in      = slot_in_i;
      cmd_d.now          = now_i;
      cmd_d.home         = '0;
      act_d              = 1'b1;
      nib_d              = 3'd0;
    end else if (act_q) begin
      cmd_d.home = hbc_pkg::bucket_step(cmd_q.home, cur_nib);
      nib_d      = nib_q + 3'd1;
      if (push) act_d = 1'b0;
    end
  end

  always_comb begin
    push_cmd      = cmd_q;
    push_cmd.home = cmd_d.home;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      nib_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      act_q <= act_d;
      nib_q <= nib_d;
      if (push) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (push) fifo_q[wp_q] <= push_cmd;
  end

  assign q_valid_o = (cnt_q != 2'd0);
  assign q_cmd_o   = fifo_q[rp_q];

endmodule
`default_nettype wire

FILE: rtl/core/hbc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbc_back
// Holds the slot table and carries out one command: for a get, a hit scan and
// on a miss a victim scan over buckets; then the table update and result beat.
// ----------------------------------------------------------------------------
module hbc_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  input  wire hbc_pkg::cmd_t q_cmd_i,
  output logic             pop_o,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [4:0]       slot_out_o
);

  localparam int unsigned SW = hbc_pkg::SlotW;
  localparam int unsigned BW = hbc_pkg::BucketW;

  logic [7:0]  dev_q  [hbc_pkg::NumSlots];
  logic [31:0] blk_q  [hbc_pkg::NumSlots];
  logic [BW-1:0] bkt_q [hbc_pkg::NumSlots];
  logic [7:0]  refs_q [hbc_pkg::NumSlots];
  logic [31:0] rel_q  [hbc_pkg::NumSlots];
  logic [hbc_pkg::NumSlots-1:0] val_q;

  hbc_pkg::bk_state_e st_q, st_d;
  hbc_pkg::cmd_t cmd_q;
  logic [SW:0]   idx_q;
  logic [BW-1:0] bsel_q;
  logic [BW:0]   bcnt_q;
  logic          found_q;
  logic [SW-1:0] best_q;
  logic [31:0]   btime_q;
  logic          hit_q;
  logic [1:0]    status_q;
  logic [4:0]    slot_q;

  logic [SW-1:0] ix;
  logic          last_ix;
  logic          is_hit, is_cand;
  logic [SW-1:0] sl;
  logic          sl_ok;

  assign ix      = idx_q[SW-1:0];
  assign last_ix = (idx_q == (SW+1)'(hbc_pkg::NumSlots - 1));
  assign is_hit  = (dev_q[ix] == cmd_q.device) && (blk_q[ix] == cmd_q.block_number);
  assign is_cand = (bkt_q[ix] == bsel_q) && (refs_q[ix] == 8'd0)
                   && (rel_q[ix] <= cmd_q.now);
  assign sl      = cmd_q.slot_in[SW-1:0];
  assign sl_ok   = ({27'd0, cmd_q.slot_in} < hbc_pkg::NumSlots);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      hbc_pkg::BK_IDLE:  if (q_valid_i) st_d = (q_cmd_i.op == hbc_pkg::OP_GET)
                                              ? hbc_pkg::BK_HIT : hbc_pkg::BK_APPLY;
      hbc_pkg::BK_HIT:   if (is_hit) st_d = hbc_pkg::BK_APPLY;
                         else if (last_ix) st_d = hbc_pkg::BK_VICT;
      hbc_pkg::BK_VICT:  if (last_ix && (found_q || is_cand
                             || bcnt_q == (BW+1)'(hbc_pkg::NumBuckets - 1)))
                           st_d = hbc_pkg::BK_APPLY;
      hbc_pkg::BK_APPLY: st_d = hbc_pkg::BK_DONE;
      hbc_pkg::BK_DONE:  st_d = hbc_pkg::BK_IDLE;
      default:           st_d = hbc_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o      = (st_q == hbc_pkg::BK_IDLE) && q_valid_i;
    done_o     = (st_q == hbc_pkg::BK_DONE);
    status_o   = status_q;
    slot_out_o = slot_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= hbc_pkg::BK_IDLE;
      val_q <= '0;
      for (int i = 0; i < hbc_pkg::NumSlots; i++) begin
        dev_q[i]  <= '0;
        blk_q[i]  <= '0;
        bkt_q[i]  <= '0;
        refs_q[i] <= '0;
        rel_q[i]  <= '0;
      end
    end else begin
      st_q <= st_d;
      if (st_q == hbc_pkg::BK_APPLY) begin
        if (cmd_q.op == hbc_pkg::OP_GET) begin
          if (hit_q) begin
            if (refs_q[best_q] != 8'hFF) begin
              refs_q[best_q] <= refs_q[best_q] + 8'd1;
              val_q[best_q]  <= 1'b1;
            end
          end else if (found_q) begin
            dev_q[best_q]  <= cmd_q.device;
            blk_q[best_q]  <= cmd_q.block_number;
            bkt_q[best_q]  <= cmd_q.home;
            refs_q[best_q] <= 8'd1;
            val_q[best_q]  <= 1'b1;
          end
        end else if (sl_ok) begin
          if (cmd_q.op == hbc_pkg::OP_PIN) begin
            if (refs_q[sl] != 8'hFF) refs_q[sl] <= refs_q[sl] + 8'd1;
          end else if (refs_q[sl] != 8'd0) begin
            refs_q[sl] <= refs_q[sl] - 8'd1;
            if (cmd_q.op == hbc_pkg::OP_RELEASE && refs_q[sl] == 8'd1)
              rel_q[sl] <= cmd_q.now;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      hbc_pkg::BK_IDLE: begin
        cmd_q   <= q_cmd_i;
        idx_q   <= '0;
        found_q <= 1'b0;
        hit_q   <= 1'b0;
        bsel_q  <= q_cmd_i.home;
        bcnt_q  <= '0;
      end
      hbc_pkg::BK_HIT: begin
        if (is_hit) begin
          hit_q  <= 1'b1;
          best_q <= ix;
        end
        idx_q <= last_ix ? '0 : idx_q + 1'b1;
      end
      hbc_pkg::BK_VICT: begin
        if (is_cand && (!found_q || rel_q[ix] < btime_q)) begin
          found_q <= 1'b1;
          best_q  <= ix;
          btime_q <= rel_q[ix];
        end
        idx_q <= last_ix ? '0 : idx_q + 1'b1;
        if (last_ix) begin
          // next bucket in ascending order, skipping home
          bcnt_q <= bcnt_q + 1'b1;
          if (bcnt_q == '0) begin
            bsel_q <= (cmd_q.home == '0) ? BW'(1) : '0;
          end else if (bsel_q + 1'b1 == cmd_q.home) begin
            bsel_q <= bsel_q + BW'(2);
          end else begin
            bsel_q <= bsel_q + 1'b1;
          end
        end
      end
      hbc_pkg::BK_APPLY: begin
        if (cmd_q.op == hbc_pkg::OP_GET) begin
          if (hit_q) begin
            slot_q   <= 5'(best_q);
            status_q <= (refs_q[best_q] == 8'hFF) ? hbc_pkg::ST_BADREF
                      : (val_q[best_q] ? hbc_pkg::ST_OK : hbc_pkg::ST_FILL);
          end else if (found_q) begin
            slot_q   <= 5'(best_q);
            status_q <= hbc_pkg::ST_FILL;
          end else begin
            slot_q   <= '0;
            status_q <= hbc_pkg::ST_NOBUF;
          end
        end else begin
          slot_q <= cmd_q.slot_in;
          if (!sl_ok) status_q <= hbc_pkg::ST_BADREF;
          else if (cmd_q.op == hbc_pkg::OP_PIN)
            status_q <= (refs_q[sl] == 8'hFF) ? hbc_pkg::ST_BADREF : hbc_pkg::ST_OK;
          else
            status_q <= (refs_q[sl] == 8'd0) ? hbc_pkg::ST_BADREF : hbc_pkg::ST_OK;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/hashed_buffer_cache_lru_timestamp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hashed_buffer_cache_lru_timestamp
// Hashed LRU disk-block buffer cache with release timestamps.
//
// Command channel: drive op_i and its operands with start_i; the command is
// taken on a clock edge where start_i is high and busy_o is low. busy_o stays
// high until the result beat has been given.
// Result channel: done_o is high for one cycle with status_o and slot_out_o;
// the receiver cannot stall it.
// Bucket hashing, one nibble a cycle, starts every command. Release, pin and
// unpin then go straight to the table update and the result beat. A get scans
// the slots one per cycle: a hit search, which stops at a hit, and on a miss
// a victim scan of each bucket visited (up to 13), which stops after the first
// bucket that holds a candidate.
// Commands are handled one at a time; the next one can be taken in the cycle
// after the result beat.
// Reset clears the whole slot table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module hashed_buffer_cache_lru_timestamp (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [7:0]  device_i,
  input  wire logic [31:0] block_number_i,
  input  wire logic [4:0]  slot_in_i,
  input  wire logic [31:0] now_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [4:0]       slot_out_o
);

  logic          pop, q_valid, busy_f;
  logic          inflight_q;
  hbc_pkg::cmd_t q_cmd;

  hbc_front u_front (
    .clk_i, .rst_ni, .start_i(start_i && !inflight_q), .op_i, .device_i,
    .block_number_i, .slot_in_i, .now_i,
    .busy_o(busy_f), .pop_i(pop), .q_valid_o(q_valid), .q_cmd_o(q_cmd)
  );

  hbc_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_cmd_i(q_cmd), .pop_o(pop),
    .done_o, .status_o, .slot_out_o
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) inflight_q <= 1'b0;
    else if (start_i && !busy_o) inflight_q <= 1'b1;
    else if (done_o) inflight_q <= 1'b0;
  end

  assign busy_o = busy_f | inflight_q;

endmodule
`default_nettype wire

FILE: bench/hashed_buffer_cache_lru_timestamp_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_buffer_cache_lru_timestamp_test
// Drives get, release, pin and unpin commands into the buffer cache and checks
// every result beat against a slot-table predictor kept inside a scoreboard.
// ----------------------------------------------------------------------------
module hashed_buffer_cache_lru_timestamp_test;
  import hbc_pkg::*;

  class cache_scoreboard;
    logic [7:0]  dev_q[NumSlots];
    logic [31:0] blk_q[NumSlots];
    bit          vld_q[NumSlots];
    logic [7:0]  refs_q[NumSlots];
    logic [31:0] rel_q[NumSlots];
    status_e     exp_status[$];
    logic [4:0]  exp_slot[$];
    int          errors;

    function new();
      errors = 0;
      for (int s = 0; s < NumSlots; s++) begin
        dev_q[s] = '0; blk_q[s] = '0; vld_q[s] = 0; refs_q[s] = '0; rel_q[s] = '0;
      end
    endfunction

    function int oldest_free(int unsigned bkt, logic [31:0] now);
      int best;
      best = -1;
      for (int s = 0; s < NumSlots; s++) begin
        if (blk_q[s] % NumBuckets != bkt || refs_q[s] != 0 || rel_q[s] > now) continue;
        if (best < 0 || rel_q[s] < rel_q[best]) best = s;
      end
      return best;
    endfunction

    function void note_cmd(op_e op, logic [7:0] dev, logic [31:0] blk,
                           logic [4:0] slot, logic [31:0] now);
      status_e st;
      logic [4:0] so;
      int v;
      int unsigned home;
      v = -1;
      so = slot;
      st = ST_OK;
      if (op == OP_GET) begin
        for (int s = 0; s < NumSlots; s++)
          if (v < 0 && dev_q[s] == dev && blk_q[s] == blk) v = s;
        if (v >= 0) begin
          so = v[4:0];
          if (refs_q[v] == 8'hff) st = ST_BADREF;
          else begin
            refs_q[v]++;
            st = vld_q[v] ? ST_OK : ST_FILL;
            vld_q[v] = 1;
          end
        end else begin
          home = blk % NumBuckets;
          v = oldest_free(home, now);
          for (int b = 0; b < NumBuckets && v < 0; b++)
            if (b != home) v = oldest_free(b, now);
          if (v < 0) begin
            st = ST_NOBUF; so = '0;
          end else begin
            dev_q[v] = dev; blk_q[v] = blk; refs_q[v] = 1; vld_q[v] = 1;
            st = ST_FILL; so = v[4:0];
          end
        end
      end else if (slot >= NumSlots) st = ST_BADREF;
      else if (op == OP_PIN) begin
        if (refs_q[slot] == 8'hff) st = ST_BADREF;
        else refs_q[slot]++;
      end else if (refs_q[slot] == 0) st = ST_BADREF;
      else begin
        refs_q[slot]--;
        if (op == OP_RELEASE && refs_q[slot] == 0) rel_q[slot] = now;
      end
      exp_status.push_back(st);
      exp_slot.push_back(so);
    endfunction

    function void check_beat(logic [1:0] st, logic [4:0] so);
      status_e es;
      logic [4:0] eso;
      if (exp_status.size() == 0) begin
        $error("result beat with nothing expected: status %0d slot %0d", st, so);
        errors++;
        return;
      end
      es = exp_status.pop_front();
      eso = exp_slot.pop_front();
      if (st !== es) begin
        $error("status: expected %0d, got %0d", es, st);
        errors++;
      end
      if (so !== eso) begin
        $error("slot_out: expected %0d, got %0d", eso, so);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start_i = 0;
  logic [1:0]  op_i = '0;
  logic [7:0]  device_i = '0;
  logic [31:0] block_number_i = '0;
  logic [4:0]  slot_in_i = '0;
  logic [31:0] now_i = '0;
  logic        busy_o, done_o;
  logic [1:0]  status_o;
  logic [4:0]  slot_out_o;

  cache_scoreboard sb = new();
  int          cycles = 0;
  int          idle_pct = 16;
  logic [31:0] tick = 32'd100;
  logic [31:0] hot_blk[8];
  logic [7:0]  hot_dev[8];

  hashed_buffer_cache_lru_timestamp DUT (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && done_o) sb.check_beat(status_o, slot_out_o);
    if (cycles > 2000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic issue(op_e op, logic [7:0] dev, logic [31:0] blk,
                       logic [4:0] slot, logic [31:0] now);
    while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    start_i <= 1;
    op_i <= op; device_i <= dev; block_number_i <= blk; slot_in_i <= slot; now_i <= now;
    do @(posedge clk_i); while (busy_o);
    sb.note_cmd(op, dev, blk, slot, now);
    start_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (sb.exp_status.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_cmd();
    int k;
    int sel;
    logic [31:0] now;
    k = $urandom_range(7);
    sel = $urandom_range(99);
    tick = tick + $urandom_range(5);
    now = ($urandom_range(19) == 0) ? $urandom : tick;
    if (sel < 45) begin
      if ($urandom_range(3) == 0) issue(OP_GET, $urandom, $urandom, '0, now);
      else issue(OP_GET, hot_dev[k], hot_blk[k], $urandom, now);
    end else if (sel < 75) issue(OP_RELEASE, $urandom, $urandom, $urandom, now);
    else if (sel < 88) issue(OP_PIN, $urandom, $urandom, $urandom, now);
    else issue(OP_UNPIN, $urandom, $urandom, $urandom, now);
  endtask

  initial begin
    for (int i = 0; i < 8; i++) begin
      hot_blk[i] = $urandom_range(60);
      hot_dev[i] = $urandom_range(3);
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: hit on reset slot, extremes, underflow, overflow, no buffer
    issue(OP_GET, 8'h00, 32'h0, 5'd0, 32'h0);
    issue(OP_GET, 8'hff, 32'hffffffff, 5'd31, 32'hffffffff);
    issue(OP_RELEASE, 8'h0, 32'h0, 5'd31, 32'h5);
    issue(OP_UNPIN, 8'h0, 32'h0, 5'd7, 32'h0);
    issue(OP_RELEASE, 8'h0, 32'h0, 5'd0, 32'd50);
    issue(OP_GET, 8'h12, 32'd13, 5'd0, 32'd10);
    issue(OP_GET, 8'h12, 32'd13, 5'd0, 32'd10);
    issue(OP_UNPIN, 8'h0, 32'h0, 5'd0, 32'd10);
    for (int i = 0; i < 256; i++) issue(OP_PIN, 8'h0, 32'h0, 5'd3, 32'h0);
    issue(OP_GET, 8'h00, 32'd0, 5'd0, 32'd0);
    for (int i = 0; i < 32; i++) issue(OP_GET, 8'h40, 32'd1000 + i, 5'd0, 32'hffffffff);
    issue(OP_GET, 8'h41, 32'd7, 5'd0, 32'd1);
    for (int i = 0; i < 32; i++)
      for (int j = 0; j < 300 && sb.refs_q[i] != 0; j++)
        issue(OP_RELEASE, 8'h0, 32'h0, i[4:0], tick + i);
    drain();
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 16 : (ph == 1) ? 61 : 0;
      for (int i = 0; i < 40; i++) random_cmd();
      drain();
    end
    repeat (500) @(posedge clk_i);
    if (sb.errors == 0 && sb.exp_status.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
